FILE: rtl/gyro_frame_deframer_core_defines.svh
// assertion macros shared by the deframer rtl
`ifndef GYRO_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define GYRO_FRAME_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication, checked on clk, quiet while rst_n is low
`define GFD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gfd check failed");

// next-cycle implication, checked on clk, quiet while rst_n is low
`define GFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gfd check failed");

`endif

FILE: rtl/gfd_pkg.sv
// constants and types shared by the gyro frame deframer
package gfd_pkg;

    localparam logic [7:0] STX_BYTE   = 8'h02;
    localparam logic [7:0] TYPE_FIRST = 8'h81;
    localparam logic [7:0] TYPE_LAST  = 8'h84;
    localparam logic [7:0] TERM_BYTE  = 8'h0d;

    localparam logic [1:0] KIND_ANGLE = 2'd0;
    localparam logic [1:0] KIND_RATE  = 2'd1;
    localparam logic [1:0] KIND_BOTH  = 2'd2;
    localparam logic [1:0] KIND_AUX   = 2'd3;

    // byte cells in the data shift line, enough for the longest frame
    localparam int DATA_CELLS = 4;

    // control handed from the frame sequencer to the top level
    typedef struct packed {
        logic       shift_en;
        logic       emit;
        logic [1:0] kind;
        logic       sum_ok;
    } gfd_ctl_t;

endpackage

FILE: rtl/gfd_ifs.sv
// valid/ready channel interfaces for serial bytes and decoded frames
interface gfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface gfd_frame_if;
    logic               valid;
    logic               ready;
    logic [1:0]         frame_kind;
    logic [15:0]        angle_code;
    logic signed [15:0] rate_code;
    logic               checksum_ok;

    modport source (output valid, output frame_kind, output angle_code,
                    output rate_code, output checksum_ok, input ready);
    modport sink (input valid, input frame_kind, input angle_code,
                  input rate_code, input checksum_ok, output ready);
endinterface

FILE: rtl/gfd_cell.sv
// one byte cell of the data shift line
module gfd_cell (
    input  logic       clk,
    input  logic       shift_en,
    input  logic [7:0] byte_in,
    output logic [7:0] byte_out
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    assign byte_next = shift_en ? byte_in : byte_reg;
    assign byte_out  = byte_reg;

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

FILE: rtl/gfd_ctrl.sv
// frame sequencer: phase tracking, running checksum and frame kind
module gfd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    output gfd_pkg::gfd_ctl_t ctl
);

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_TYPE,
        PH_STATUS,
        PH_D0,
        PH_D1,
        PH_D2,
        PH_D3,
        PH_CHECK,
        PH_TERM
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] sum_reg, sum_next;
    logic       match_reg, match_next;
    logic [7:0] type_off;
    logic       type_hit;

    assign type_off = data_byte - gfd_pkg::TYPE_FIRST;
    assign type_hit = (data_byte >= gfd_pkg::TYPE_FIRST) && (data_byte <= gfd_pkg::TYPE_LAST);

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        sum_next   = sum_reg;
        match_next = match_reg;
        unique case (phase_reg)
            PH_TYPE:
            begin
                if (type_hit)
                begin
                    kind_next  = type_off[1:0];
                    sum_next   = data_byte;
                    phase_next = PH_STATUS;
                end
                else if (data_byte == gfd_pkg::STX_BYTE)
                begin
                    phase_next = PH_TYPE;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_STATUS:
            begin
                sum_next   = sum_reg + data_byte;
                phase_next = PH_D0;
            end
            PH_D0:
            begin
                sum_next   = sum_reg + data_byte;
                phase_next = PH_D1;
            end
            PH_D1:
            begin
                sum_next   = sum_reg + data_byte;
                phase_next = (kind_reg == gfd_pkg::KIND_BOTH) ? PH_D2 : PH_CHECK;
            end
            PH_D2:
            begin
                sum_next   = sum_reg + data_byte;
                phase_next = PH_D3;
            end
            PH_D3:
            begin
                sum_next   = sum_reg + data_byte;
                phase_next = PH_CHECK;
            end
            PH_CHECK:
            begin
                match_next = (data_byte == sum_reg);
                phase_next = PH_TERM;
            end
            PH_TERM:
            begin
                phase_next = PH_HUNT;
            end
            default:
            begin
                phase_next = (data_byte == gfd_pkg::STX_BYTE) ? PH_TYPE : PH_HUNT;
            end
        endcase
    end

    always_comb
    begin
        ctl.shift_en = accept && ((phase_reg == PH_D0) || (phase_reg == PH_D1) ||
                                  (phase_reg == PH_D2) || (phase_reg == PH_D3));
        ctl.emit     = accept && (phase_reg == PH_TERM) && (data_byte == gfd_pkg::TERM_BYTE);
        ctl.kind     = kind_reg;
        ctl.sum_ok   = match_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            kind_reg  <= 2'd0;
            sum_reg   <= 8'd0;
            match_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            sum_reg   <= sum_next;
            match_reg <= match_next;
        end
    end

endmodule

FILE: rtl/gyro_frame_deframer_core.sv
// gyro serial frame deframer top level: sequencer, byte cell line, output register
//
//   channel  dir  payload                                          role
//   rx       in   data_byte[7:0]                                   received serial bytes
//   frame    out  frame_kind, angle_code, rate_code, checksum_ok   one per terminated frame
//
// one byte is taken every cycle while rx is not stalled; a frame result appears the cycle after its terminator
// data bytes shift through a line of four byte cells, the sequencer steps once per byte
// rst_n clears the sequencer phase and the output valid; cell contents are left alone
// rx stalls only while a finished frame sits unclaimed in the output register
`include "gyro_frame_deframer_core_defines.svh"

module gyro_frame_deframer_core (
    input  logic       clk,
    input  logic       rst_n,
    gfd_byte_if.sink   rx,
    gfd_frame_if.source frame
);

    localparam int CELLS = gfd_pkg::DATA_CELLS;

    gfd_pkg::gfd_ctl_t ctl;
    logic              accept;
    logic [7:0]        cell_q [CELLS];
    logic [15:0]       first_word;
    logic [15:0]       second_word;

    logic              valid_reg, valid_next;
    logic [1:0]        kind_reg;
    logic [15:0]       angle_reg;
    logic [15:0]       rate_reg;
    logic              ok_reg;
    logic [15:0]       angle_next;
    logic [15:0]       rate_next;

    assign rx.ready = !valid_reg || frame.ready;
    assign accept   = rx.valid && rx.ready;

    gfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (rx.data_byte),
        .ctl       (ctl)
    );

    // cell 0 takes the newest data byte, older bytes move up the line
    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            gfd_cell u_cell (
                .clk      (clk),
                .shift_en (ctl.shift_en),
                .byte_in  (rx.data_byte),
                .byte_out (cell_q[i])
            );
        end
        else
        begin : g_body
            gfd_cell u_cell (
                .clk      (clk),
                .shift_en (ctl.shift_en),
                .byte_in  (cell_q[i-1]),
                .byte_out (cell_q[i])
            );
        end
    end

    // big-endian words; a four byte frame pushes its first word two cells further
    always_comb
    begin
        second_word = {cell_q[1], cell_q[0]};
        if (ctl.kind == gfd_pkg::KIND_BOTH)
        begin
            first_word = {cell_q[3], cell_q[2]};
        end
        else
        begin
            first_word = {cell_q[1], cell_q[0]};
        end
    end

    always_comb
    begin
        case (ctl.kind)
            gfd_pkg::KIND_RATE:
            begin
                angle_next = 16'd0;
                rate_next  = first_word;
            end
            gfd_pkg::KIND_BOTH:
            begin
                angle_next = first_word;
                rate_next  = second_word;
            end
            default:
            begin
                angle_next = first_word;
                rate_next  = 16'd0;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.emit)
        begin
            valid_next = 1'b1;
        end
        else if (frame.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            kind_reg  <= ctl.kind;
            angle_reg <= angle_next;
            rate_reg  <= rate_next;
            ok_reg    <= ctl.sum_ok;
        end
    end

    assign frame.valid       = valid_reg;
    assign frame.frame_kind  = kind_reg;
    assign frame.angle_code  = angle_reg;
    assign frame.rate_code   = $signed(rate_reg);
    assign frame.checksum_ok = ok_reg;

    `GFD_ASSERT_NEXT(a_emit_shows, ctl.emit, frame.valid)
    `GFD_ASSERT_SAME(a_shift_not_emit, ctl.shift_en, !ctl.emit)
    `GFD_ASSERT_SAME(a_stall_blocks_rx, frame.valid && !frame.ready, !rx.ready)

endmodule
